>>> rtl/core/median_of_sample_set_top_assert.svh
// Assertion macros shared by the median block.
// Every macro expects the signals aclk and aresetn in the scope where it is used.
`ifndef MEDIAN_OF_SAMPLE_SET_TOP_ASSERT_SVH
`define MEDIAN_OF_SAMPLE_SET_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MOS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("median block: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("median block: next-cycle check failed");

`endif

>>> rtl/core/mos_pkg.sv
// Shared types and constants of the median-of-sample-set block.
// No dependencies; used by mos_cell and median_of_sample_set_top.
`default_nettype none

package mos_pkg;

    localparam int MEDIAN_WIDTH  = 17;
    localparam int SIZE_WIDTH    = 7;
    localparam int M_TDATA_WIDTH = 24;

    // Control that the sequencer broadcasts to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic drain;
    } mos_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } mos_state_t;

endpackage

`default_nettype wire

>>> rtl/core/median_of_sample_set_top.sv
// Top level of the median block: a chain of mos_cell instances, types from mos_pkg.
// A word marked last starts the drain: the chain shifts that bring the middle samples to the
// bottom cells follow, then the output register is loaded once it is free. Throughput: one
// sample word per cycle while loading; after the last word of a set the input stalls during
// the shifts and the output load, longer while an earlier result still waits. Reset (aresetn
// low, synchronous) empties the set, clears the drop flag and the output valid.
`default_nettype none

module median_of_sample_set_top #(
    parameter int MAX_COUNT    = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample, rest zero padding
    input  wire  [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input  wire                                   s_axis_tlast,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // [16:0] median_x2, [23:17] set_size
    output logic [mos_pkg::M_TDATA_WIDTH-1:0]     m_axis_tdata,
    // [0] overflowed
    output logic                                  m_axis_tuser
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);

    mos_pkg::mos_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] drain_cnt_reg, drain_cnt_next;
    logic             drop_reg, drop_next;
    logic             odd_reg, odd_next;
    logic             m_valid_reg, m_valid_next;
    logic [mos_pkg::MEDIAN_WIDTH-1:0] median_reg, median_next;
    logic [mos_pkg::SIZE_WIDTH-1:0]   size_reg, size_next;
    logic             ovf_reg, ovf_next;

    mos_pkg::mos_ctrl_t ctrl;
    logic                           in_accept;
    logic                           has_room;
    logic [CNT_W-1:0]               n_after;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic signed [SAMPLE_WIDTH-1:0] cell_value [MAX_COUNT];
    logic                           cell_gt    [MAX_COUNT];
    logic signed [SAMPLE_WIDTH:0]   mid_lo, mid_hi, mid_sum;

    assign sample        = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign s_axis_tready = (state_reg == mos_pkg::ST_LOAD);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign has_room      = (count_reg != CNT_W'(MAX_COUNT));
    assign n_after       = has_room ? count_reg + CNT_W'(1) : count_reg;

    assign ctrl = '{insert: in_accept && has_room,
                    drain:  (state_reg == mos_pkg::ST_DRAIN) && (drain_cnt_reg != '0)};

    genvar i;
    generate
        for (i = 0; i < MAX_COUNT; i++) begin : g_cell
            logic                           left_gt;
            logic signed [SAMPLE_WIDTH-1:0] left_value;
            logic signed [SAMPLE_WIDTH-1:0] right_value;

            if (i == 0) begin : g_first
                assign left_gt    = 1'b0;
                assign left_value = sample;
            end else begin : g_inner
                assign left_gt    = cell_gt[i-1];
                assign left_value = cell_value[i-1];
            end

            if (i == MAX_COUNT - 1) begin : g_end
                assign right_value = cell_value[i];
            end else begin : g_mid
                assign right_value = cell_value[i+1];
            end

            mos_cell #(
                .SAMPLE_WIDTH(SAMPLE_WIDTH)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (count_reg > CNT_W'(i)),
                .is_tail    (count_reg == CNT_W'(i)),
                .new_sample (sample),
                .left_gt    (left_gt),
                .left_value (left_value),
                .right_value(right_value),
                .gt         (cell_gt[i]),
                .value      (cell_value[i])
            );
        end
    endgenerate

    // After the shifts the lower middle sample sits in cell 0 and the upper one in cell 1.
    assign mid_lo  = (SAMPLE_WIDTH+1)'(cell_value[0]);
    assign mid_hi  = odd_reg ? mid_lo : (SAMPLE_WIDTH+1)'(cell_value[1]);
    assign mid_sum = mid_lo + mid_hi;

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        drain_cnt_next = drain_cnt_reg;
        drop_next      = drop_reg;
        odd_next       = odd_reg;
        m_valid_next   = m_valid_reg;
        median_next    = median_reg;
        size_next      = size_reg;
        ovf_next       = ovf_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            mos_pkg::ST_LOAD: begin
                if (in_accept) begin
                    count_next = n_after;
                    if (!has_room) begin
                        drop_next = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        drain_cnt_next = (n_after - CNT_W'(1)) >> 1;
                        odd_next       = n_after[0];
                        state_next     = mos_pkg::ST_DRAIN;
                    end
                end
            end
            mos_pkg::ST_DRAIN: begin
                if (drain_cnt_reg != '0) begin
                    drain_cnt_next = drain_cnt_reg - CNT_W'(1);
                end else if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    median_next  = mos_pkg::MEDIAN_WIDTH'(mid_sum);
                    size_next    = mos_pkg::SIZE_WIDTH'(count_reg);
                    ovf_next     = drop_reg;
                    count_next   = '0;
                    drop_next    = 1'b0;
                    state_next   = mos_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = mos_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mos_pkg::ST_LOAD;
            count_reg     <= '0;
            drain_cnt_reg <= '0;
            drop_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drain_cnt_reg <= drain_cnt_next;
            drop_reg      <= drop_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        odd_reg    <= odd_next;
        median_reg <= median_next;
        size_reg   <= size_next;
        ovf_reg    <= ovf_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {size_reg, median_reg};
    assign m_axis_tuser  = ovf_reg;

`include "median_of_sample_set_top_assert.svh"

    `MOS_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= CNT_W'(MAX_COUNT))
    `MOS_ASSERT_SAME(a_result_from_drain, $rose(m_axis_tvalid),
        $past(state_reg) == mos_pkg::ST_DRAIN && state_reg == mos_pkg::ST_LOAD)
    `MOS_ASSERT_SAME(a_set_cleared, $rose(m_axis_tvalid), count_reg == '0 && !drop_reg)
    `MOS_ASSERT_NEXT(a_last_starts_drain, in_accept && s_axis_tlast,
        state_reg == mos_pkg::ST_DRAIN)

endmodule

`default_nettype wire

>>> rtl/core/mos_cell.sv
// One cell of the insertion chain: holds one sample of the sorted set.
// Depends on mos_pkg for the control struct.
`default_nettype none

module mos_cell #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                           aclk,
    input  wire mos_pkg::mos_ctrl_t       ctrl,
    input  wire                           occupied,
    input  wire                           is_tail,
    input  wire signed [SAMPLE_WIDTH-1:0] new_sample,
    input  wire                           left_gt,
    input  wire signed [SAMPLE_WIDTH-1:0] left_value,
    input  wire signed [SAMPLE_WIDTH-1:0] right_value,
    output logic                          gt,
    output logic signed [SAMPLE_WIDTH-1:0] value
);

    logic signed [SAMPLE_WIDTH-1:0] value_reg;
    logic signed [SAMPLE_WIDTH-1:0] value_next;

    // The held sample is larger than the arriving one, so it moves one place up.
    assign gt    = occupied && (value_reg > new_sample);
    assign value = value_reg;

    always_comb begin
        value_next = value_reg;
        if (ctrl.drain) begin
            value_next = right_value;
        end else if (ctrl.insert) begin
            if (left_gt) begin
                value_next = left_value;
            end else if (gt || is_tail) begin
                value_next = new_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire
